// ----- hw/rtl/planar_odometry_integrator_assert.svh -----
// assertion macros used by the pose integrator checker
`ifndef PLANAR_ODOMETRY_INTEGRATOR_ASSERT_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_ASSERT_SVH

// same-cycle implication, muted while reset is high
`define POI_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, muted while reset is high
`define POI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define POI_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/poi_pkg.sv -----
// shared types, constants and tables of the pose integrator
`default_nettype none

package poi_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int ATAN_IDX_W   = 5;

   localparam int VEL_W     = 24;
   localparam int DT_W      = 16;
   localparam int POS_W     = 32;
   localparam int POS_EXT_W = POS_W + 2;
   localparam int HEAD_W    = 31;
   localparam int CX_W      = 35;
   localparam int Z_W       = 32;
   localparam int RX_W      = 34;
   localparam int TURN_W    = 36;
   localparam int MUL_A_W   = 36;
   localparam int MUL_B_W   = 25;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int SH_W      = 5;
   localparam int WRAP_W    = 39;
   localparam int WRAP_K_W  = 3;

   localparam int VEL_SCALE_SH = 8;
   localparam int GAIN_SH      = 24;
   localparam int TURN_SH      = 4;
   localparam int WRAP_TOP_K   = 6;

   localparam longint PI_Q      = 843314857;
   localparam longint TWO_PI_Q  = 1686629713;
   localparam longint HALF_PI_Q = 421657428;
   localparam longint GAIN_Q24  = 10188014;
   // keeps heading + pi positive for any turn before the reduction
   localparam longint WRAP_BIAS = PI_Q + (TWO_PI_Q << WRAP_TOP_K);

   localparam longint RESET_POS     = 32768;
   localparam longint RESET_HEADING = 421657421;

   typedef struct packed {
      logic              load;
      logic              step;
      logic [STEP_W-1:0] idx;
   } cordic_ctl_type;

   typedef struct packed {
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
      logic                      short_round;
   } mul_op_type;

   // arctangent of 2^-i in Q3.28
   function automatic logic signed [Z_W-1:0] atan_q(input logic [ATAN_IDX_W-1:0] idx);
      case (idx)
         5'd0:    atan_q = 32'sd210828714;
         5'd1:    atan_q = 32'sd124459457;
         5'd2:    atan_q = 32'sd65760959;
         5'd3:    atan_q = 32'sd33381290;
         5'd4:    atan_q = 32'sd16755422;
         5'd5:    atan_q = 32'sd8385879;
         5'd6:    atan_q = 32'sd4193963;
         5'd7:    atan_q = 32'sd2097109;
         5'd8:    atan_q = 32'sd1048571;
         5'd9:    atan_q = 32'sd524287;
         5'd10:   atan_q = 32'sd262144;
         5'd11:   atan_q = 32'sd131072;
         5'd12:   atan_q = 32'sd65536;
         5'd13:   atan_q = 32'sd32768;
         5'd14:   atan_q = 32'sd16384;
         5'd15:   atan_q = 32'sd8192;
         5'd16:   atan_q = 32'sd4096;
         5'd17:   atan_q = 32'sd2048;
         5'd18:   atan_q = 32'sd1024;
         5'd19:   atan_q = 32'sd512;
         5'd20:   atan_q = 32'sd256;
         5'd21:   atan_q = 32'sd128;
         5'd22:   atan_q = 32'sd64;
         5'd23:   atan_q = 32'sd32;
         5'd24:   atan_q = 32'sd16;
         5'd25:   atan_q = 32'sd8;
         5'd26:   atan_q = 32'sd4;
         5'd27:   atan_q = 32'sd2;
         5'd28:   atan_q = 32'sd1;
         default: atan_q = 32'sd0;
      endcase
   endfunction

   // clamp a widened position sum to the signed 32-bit range
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_EXT_W-1:0] v);
      logic [2:0] top;
      top = v[POS_EXT_W-1:POS_W-1];
      if (top == 3'b000 || top == 3'b111) begin
         sat_pos = v[POS_W-1:0];
      end else if (v[POS_EXT_W-1]) begin
         sat_pos = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         sat_pos = {1'b0, {(POS_W-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/poi_if.sv -----
// request and response channel interfaces of the pose integrator
`default_nettype none

interface poi_req_if import poi_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic signed [VEL_W-1:0]  vel_x;
   logic signed [VEL_W-1:0]  vel_y;
   logic signed [VEL_W-1:0]  turn_rate;
   logic        [DT_W-1:0]   step_time;
   logic signed [POS_W-1:0]  load_x;
   logic signed [POS_W-1:0]  load_y;
   logic signed [HEAD_W-1:0] load_heading;

   modport source (
      output valid, mode, vel_x, vel_y, turn_rate, step_time, load_x, load_y, load_heading,
      input  ready
   );
   modport sink (
      input  valid, mode, vel_x, vel_y, turn_rate, step_time, load_x, load_y, load_heading,
      output ready
   );
endinterface

interface poi_rsp_if import poi_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic signed [HEAD_W-1:0] heading;

   modport source (
      output valid, pos_x, pos_y, heading,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, heading,
      output ready
   );
endinterface

`default_nettype wire

// ----- hw/rtl/poi_cordic_unit.sv -----
// iterative cordic rotator, one micro-rotation per cycle
`default_nettype none

module poi_cordic_unit import poi_pkg::*; (
   input  wire logic                     clock,
   input  wire cordic_ctl_type           ctl,
   input  wire logic signed [VEL_W-1:0]  vel_x,
   input  wire logic signed [VEL_W-1:0]  vel_y,
   input  wire logic signed [HEAD_W-1:0] angle,
   output logic signed [CX_W-1:0]        x,
   output logic signed [CX_W-1:0]        y
);

   logic signed [CX_W-1:0] x_ff, x_in;
   logic signed [CX_W-1:0] y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;

   logic signed [CX_W-1:0] sx, sy, dx, dy;
   logic signed [Z_W-1:0]  z0, ang;

   always_comb begin
      sx  = CX_W'(vel_x) <<< VEL_SCALE_SH;
      sy  = CX_W'(vel_y) <<< VEL_SCALE_SH;
      z0  = Z_W'(angle);
      dx  = y_ff >>> ctl.idx;
      dy  = x_ff >>> ctl.idx;
      ang = atan_q(ATAN_IDX_W'(ctl.idx));
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (ctl.load) begin
         // quarter-turn pre-rotation brings the angle into cordic range
         if (z0 > Z_W'(HALF_PI_Q)) begin
            x_in = -sy;
            y_in = sx;
            z_in = z0 - Z_W'(HALF_PI_Q);
         end else if (z0 < -Z_W'(HALF_PI_Q)) begin
            x_in = sy;
            y_in = -sx;
            z_in = z0 + Z_W'(HALF_PI_Q);
         end else begin
            x_in = sx;
            y_in = sy;
            z_in = z0;
         end
      end else if (ctl.step) begin
         if (!z_ff[Z_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x = x_ff;
   assign y = y_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/poi_mul_unit.sv -----
// shared registered multiplier with round-half-up scaling
`default_nettype none

module poi_mul_unit import poi_pkg::*; (
   input  wire logic                  clock,
   input  wire mul_op_type            op,
   output logic signed [MUL_P_W-1:0] result
);

   logic signed [MUL_P_W-1:0] prod_ff;
   logic                      short_ff;
   logic        [SH_W-1:0]    shift_amt;

   always_ff @(posedge clock) begin
      prod_ff  <= op.a * op.b;
      short_ff <= op.short_round;
   end

   always_comb begin
      shift_amt = short_ff ? SH_W'(TURN_SH) : SH_W'(GAIN_SH);
      result    = (prod_ff + (MUL_P_W'(1) <<< (shift_amt - SH_W'(1)))) >>> shift_amt;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/planar_odometry_integrator.sv -----
// top level of the planar dead-reckoning pose integrator
//
//   channel  dir  handshake      payload
//   req_bus  in   valid / ready  mode, vel_x, vel_y, turn_rate, step_time,
//                                load_x, load_y, load_heading
//   rsp_bus  out  valid / ready  pos_x, pos_y, heading
//
// between accept and the next accept an update request runs the cordic
// iterations, five passes through the shared multiplier and seven
// conditional subtracts of the heading wrap
// a load-pose request runs the heading wrap alone
// synchronous reset puts the pose at (0.5 m, 0.5 m, pi/2) and drops rsp valid
// a stalled response sits in its own register, so the next request is taken
// meanwhile; only the finish of the following request waits for it
`default_nettype none

module planar_odometry_integrator import poi_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   poi_req_if.sink   req_bus,
   poi_rsp_if.source rsp_bus
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROTATE,
      S_GAIN_X,
      S_GAIN_Y,
      S_SCALE_X,
      S_SCALE_Y,
      S_TURN,
      S_HSUM,
      S_WRAP,
      S_DONE
   } state_type;

   state_type state_ff;

   // sequencer counters
   logic [STEP_W-1:0]   step_ff;
   logic [WRAP_K_W-1:0] wk_ff;

   // request fields kept past the accept
   logic signed [VEL_W-1:0] rate_ff;
   logic        [DT_W-1:0]  dt_ff;

   // rotated, gain-corrected velocity
   logic signed [RX_W-1:0] rx_ff;
   logic signed [RX_W-1:0] ry_ff;

   // pose state
   logic signed [POS_W-1:0]  x_ff;
   logic signed [POS_W-1:0]  y_ff;
   logic signed [HEAD_W-1:0] head_ff;

   // heading + pi + bias, reduced mod 2 pi by restoring subtracts
   logic signed [WRAP_W-1:0] acc_ff;

   // response register
   logic                     rsp_valid_ff;
   logic signed [POS_W-1:0]  rsp_x_ff;
   logic signed [POS_W-1:0]  rsp_y_ff;
   logic signed [HEAD_W-1:0] rsp_head_ff;

   logic req_fire;
   logic rsp_free;

   cordic_ctl_type           cordic_ctl;
   logic signed [CX_W-1:0]   cx, cy;
   mul_op_type               mul_op;
   logic signed [MUL_P_W-1:0] mul_res;

   logic signed [POS_EXT_W-1:0] sum_pos;
   logic signed [WRAP_W-1:0]    wrap_sub;
   logic signed [WRAP_W-1:0]    heading_in;
   logic signed [MUL_B_W-1:0]   dt_op;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready   = (state_ff == S_IDLE);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.pos_x   = rsp_x_ff;
   assign rsp_bus.pos_y   = rsp_y_ff;
   assign rsp_bus.heading = rsp_head_ff;

   // cordic starts from the heading held before this request's turn
   always_comb begin
      cordic_ctl.load = req_fire && !req_bus.mode;
      cordic_ctl.step = (state_ff == S_ROTATE);
      cordic_ctl.idx  = step_ff;
   end

   poi_cordic_unit u_cordic (
      .clock (clock),
      .ctl   (cordic_ctl),
      .vel_x (req_bus.vel_x),
      .vel_y (req_bus.vel_y),
      .angle (head_ff),
      .x     (cx),
      .y     (cy)
   );

   // multiplier schedule: the product issued in one state is read in the next
   always_comb begin
      dt_op = signed'({{(MUL_B_W-DT_W){1'b0}}, dt_ff});
      mul_op.a           = '0;
      mul_op.b           = '0;
      mul_op.short_round = 1'b0;
      case (state_ff)
         S_GAIN_X: begin
            mul_op.a = MUL_A_W'(cx);
            mul_op.b = MUL_B_W'(GAIN_Q24);
         end
         S_GAIN_Y: begin
            mul_op.a = MUL_A_W'(cy);
            mul_op.b = MUL_B_W'(GAIN_Q24);
         end
         S_SCALE_X: begin
            mul_op.a = MUL_A_W'(rx_ff);
            mul_op.b = dt_op;
         end
         S_SCALE_Y: begin
            mul_op.a = MUL_A_W'(ry_ff);
            mul_op.b = dt_op;
         end
         S_TURN: begin
            mul_op.a           = MUL_A_W'(rate_ff);
            mul_op.b           = dt_op;
            mul_op.short_round = 1'b1;
         end
         default: begin
            mul_op.a = '0;
         end
      endcase
   end

   poi_mul_unit u_mul (
      .clock  (clock),
      .op     (mul_op),
      .result (mul_res)
   );

   always_comb begin
      // displacement of x in scale_y, of y in turn
      sum_pos    = POS_EXT_W'(state_ff == S_SCALE_Y ? x_ff : y_ff)
                 + signed'(mul_res[POS_EXT_W-1:0]);
      wrap_sub   = WRAP_W'(TWO_PI_Q) << wk_ff;
      heading_in = acc_ff - WRAP_W'(PI_Q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         wk_ff        <= '0;
         x_ff         <= POS_W'(RESET_POS);
         y_ff         <= POS_W'(RESET_POS);
         head_ff      <= HEAD_W'(RESET_HEADING);
         rsp_valid_ff <= 1'b0;
      end else begin
         // the done state reloads the response register itself
         if (rsp_valid_ff && rsp_bus.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  rate_ff <= req_bus.turn_rate;
                  dt_ff   <= req_bus.step_time;
                  step_ff <= '0;
                  if (req_bus.mode) begin
                     // load pose: only the heading needs work
                     x_ff     <= req_bus.load_x;
                     y_ff     <= req_bus.load_y;
                     acc_ff   <= WRAP_W'(req_bus.load_heading) + WRAP_W'(WRAP_BIAS);
                     wk_ff    <= WRAP_K_W'(WRAP_TOP_K);
                     state_ff <= S_WRAP;
                  end else begin
                     state_ff <= S_ROTATE;
                  end
               end
            end
            S_ROTATE: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
                  state_ff <= S_GAIN_X;
               end
            end
            S_GAIN_X: begin
               state_ff <= S_GAIN_Y;
            end
            S_GAIN_Y: begin
               rx_ff    <= mul_res[RX_W-1:0];
               state_ff <= S_SCALE_X;
            end
            S_SCALE_X: begin
               ry_ff    <= mul_res[RX_W-1:0];
               state_ff <= S_SCALE_Y;
            end
            S_SCALE_Y: begin
               x_ff     <= sat_pos(sum_pos);
               state_ff <= S_TURN;
            end
            S_TURN: begin
               y_ff     <= sat_pos(sum_pos);
               state_ff <= S_HSUM;
            end
            S_HSUM: begin
               acc_ff   <= WRAP_W'(head_ff) + WRAP_W'(signed'(mul_res[TURN_W-1:0]))
                         + WRAP_W'(WRAP_BIAS);
               wk_ff    <= WRAP_K_W'(WRAP_TOP_K);
               state_ff <= S_WRAP;
            end
            S_WRAP: begin
               // restoring reduction by 2 pi times a falling power of two
               if (acc_ff >= wrap_sub) begin
                  acc_ff <= acc_ff - wrap_sub;
               end
               wk_ff <= wk_ff - WRAP_K_W'(1);
               if (wk_ff == '0) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // waits only while an older response is still held
               if (rsp_free) begin
                  head_ff      <= heading_in[HEAD_W-1:0];
                  rsp_x_ff     <= x_ff;
                  rsp_y_ff     <= y_ff;
                  rsp_head_ff  <= heading_in[HEAD_W-1:0];
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/poi_checker.sv -----
// port-level assertions for the pose integrator and their bind
`default_nettype none

`include "planar_odometry_integrator_assert.svh"

module poi_checker import poi_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic signed [POS_W-1:0]  rsp_pos_x,
   input wire logic signed [POS_W-1:0]  rsp_pos_y,
   input wire logic signed [HEAD_W-1:0] rsp_heading
);

   // one request in flight at a time
   `POI_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   // a held response keeps its payload
   `POI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_heading), "response changed while stalled")

   // heading always leaves wrapped into [-pi, pi)
   `POI_ASSERT_SAME(a_heading_range, clock, reset, rsp_valid, (rsp_heading >= -PI_Q) && (rsp_heading <= PI_Q - 1), "heading out of range")

   // reset leaves the block idle with nothing to deliver
   `POI_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid && req_ready, "not idle after reset")

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_pos_x   (rsp_bus.pos_x),
   .rsp_pos_y   (rsp_bus.pos_y),
   .rsp_heading (rsp_bus.heading)
);

`default_nettype wire

// ----- test/planar_odometry_integrator_tb.sv -----
// self-checking testbench of the planar dead-reckoning pose integrator
`default_nettype none

module planar_odometry_integrator_tb import poi_pkg::*;;

   // request kinds on the mode bit
   localparam logic MODE_UPDATE = 1'b0;
   localparam logic MODE_LOAD   = 1'b1;

   // fixed-point angle constants, Q3.28 radians
   localparam longint Q_PI      = 843314857;
   localparam longint Q_TWO_PI  = 1686629713;
   localparam longint Q_HALF_PI = 421657428;
   // cordic gain compensation, 0.6072529 in Q.24
   localparam longint Q_GAIN    = 10188014;

   localparam longint POSE_MAX = 2147483647;
   localparam longint POSE_MIN = -POSE_MAX - 1;

   // pose right after reset: 0.5 m, 0.5 m, just under pi/2
   localparam longint HOME_POS     = 32768;
   localparam longint HOME_HEADING = 421657421;

   localparam int TABLE_LEN = 30;
   localparam int ROT_STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

   // arctangent of 2^-i, Q3.28
   localparam longint ARCTAN_Q [TABLE_LEN] = '{
      210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
      4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0
   };

   localparam logic signed [VEL_W-1:0]  VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
   localparam logic signed [VEL_W-1:0]  VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
   localparam logic        [DT_W-1:0]   DT_MAX  = '1;
   localparam logic signed [POS_W-1:0]  X_MAX   = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0]  X_MIN   = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic signed [HEAD_W-1:0] YAW_MAX = {1'b0, {(HEAD_W-1){1'b1}}};
   localparam logic signed [HEAD_W-1:0] YAW_MIN = {1'b1, {(HEAD_W-1){1'b0}}};

   localparam int RANDOM_ITEMS = 925;
   localparam int WAIT_MAX     = 17;
   localparam int LONG_HOLD    = 400;
   localparam int IDLE_LIMIT   = 3000;   // cycles with no handshake at all
   localparam int TAIL_CYCLES  = 60;     // longer than one update latency

   typedef struct {
      logic                     mode;
      logic signed [VEL_W-1:0]  vel_x;
      logic signed [VEL_W-1:0]  vel_y;
      logic signed [VEL_W-1:0]  turn_rate;
      logic        [DT_W-1:0]   step_time;
      logic signed [POS_W-1:0]  load_x;
      logic signed [POS_W-1:0]  load_y;
      logic signed [HEAD_W-1:0] load_heading;
      bit                       drain_first;   // hold back until all responses are in
   } odo_request_type;

   typedef struct {
      logic signed [POS_W-1:0]  x;
      logic signed [POS_W-1:0]  y;
      logic signed [HEAD_W-1:0] heading;
   } pose_type;

   logic clock = 1'b0;
   logic reset;

   poi_req_if req_bus ();
   poi_rsp_if rsp_bus ();

   planar_odometry_integrator u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #1 clock = ~clock;

   // requests waiting to be driven, poses waiting to come back
   odo_request_type queued_requests [$];
   pose_type        pending_poses [$];

   // tracked pose of the integrator
   longint track_x;
   longint track_y;
   longint track_heading;

   int fail_count;
   int results_seen;
   int launched;
   int n_updates;
   int n_loads;
   int n_clamps;
   int n_quadrant;
   int idle_cycles;

   // handshake flags, refreshed at every rising edge
   logic req_fire;
   logic rsp_fire;

   // ---------------------------------------------------------------
   // arithmetic helpers
   // ---------------------------------------------------------------

   // round half up, dropping k fraction bits
   function automatic longint round_off(longint v, int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
   endfunction

   // fold an angle into [-pi, pi)
   function automatic longint fold_angle(longint h);
      longint m;
      m = (h + Q_PI) % Q_TWO_PI;
      if (m < 0) begin
         m += Q_TWO_PI;
      end
      return m - Q_PI;
   endfunction

   function automatic longint clamp_pos(longint v);
      if (v > POSE_MAX || v < POSE_MIN) begin
         n_clamps++;
      end
      if (v > POSE_MAX) begin
         return POSE_MAX;
      end
      if (v < POSE_MIN) begin
         return POSE_MIN;
      end
      return v;
   endfunction

   // body velocity rotated into the world frame, gain corrected
   function automatic void rotate_body(input longint vx, input longint vy, input longint ang,
                                       output longint rx, output longint ry);
      longint x, y, z, t, dx, dy;
      x = vx * 256;
      y = vy * 256;
      z = ang;
      // outside +-pi/2 a quarter turn first keeps the cordic in its range
      if (z > Q_HALF_PI) begin
         t = x; x = -y; y = t; z -= Q_HALF_PI;
         n_quadrant++;
      end else if (z < -Q_HALF_PI) begin
         t = x; x = y; y = -t; z += Q_HALF_PI;
         n_quadrant++;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ARCTAN_Q[i];
         end else begin
            x += dx; y -= dy; z += ARCTAN_Q[i];
         end
      end
      rx = round_off(x * Q_GAIN, 24);
      ry = round_off(y * Q_GAIN, 24);
   endfunction

   // apply one request to the tracked pose and return the pose it yields
   function automatic pose_type advance_pose(odo_request_type r);
      longint   rx, ry, dt;
      pose_type p;
      if (r.mode == MODE_LOAD) begin
         n_loads++;
         track_x       = r.load_x;
         track_y       = r.load_y;
         track_heading = fold_angle(longint'(r.load_heading));
      end else begin
         n_updates++;
         dt = longint'(r.step_time);
         // rotation uses the heading from before this request's turn
         rotate_body(longint'(r.vel_x), longint'(r.vel_y), track_heading, rx, ry);
         track_x       = clamp_pos(track_x + round_off(rx * dt, 24));
         track_y       = clamp_pos(track_y + round_off(ry * dt, 24));
         track_heading = fold_angle(track_heading + round_off(longint'(r.turn_rate) * dt, 4));
      end
      p.x       = track_x[POS_W-1:0];
      p.y       = track_y[POS_W-1:0];
      p.heading = track_heading[HEAD_W-1:0];
      return p;
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // wait cycles per request; every fourth run of 40 goes without gaps
   function automatic int draw_wait(int seq);
      if ((seq / 40) % 4 == 3) begin
         return 0;
      end
      return $urandom_range(0, WAIT_MAX);
   endfunction

   function automatic logic signed [VEL_W-1:0] pick_vel();
      case ($urandom_range(0, 9))
         0:       return VEL_MAX;
         1:       return VEL_MIN;
         2, 3:    return VEL_W'($urandom_range(0, 4096) - 2048);   // slow crawl
         default: return VEL_W'($urandom());
      endcase
   endfunction

   function automatic logic signed [POS_W-1:0] pick_pos();
      case ($urandom_range(0, 9))
         0:       return X_MAX;
         1:       return X_MIN;
         2:       return X_MAX - $urandom_range(0, 1 << 20);   // close to the top
         3:       return X_MIN + $urandom_range(0, 1 << 20);   // close to the bottom
         default: return $urandom();
      endcase
   endfunction

   // load fields of an update carry noise, the block must ignore them
   task automatic add_update(input logic signed [VEL_W-1:0] vx, input logic signed [VEL_W-1:0] vy,
                             input logic signed [VEL_W-1:0] rate, input logic [DT_W-1:0] dt);
      odo_request_type r;
      r.mode         = MODE_UPDATE;
      r.vel_x        = vx;
      r.vel_y        = vy;
      r.turn_rate    = rate;
      r.step_time    = dt;
      r.load_x       = $urandom();
      r.load_y       = $urandom();
      r.load_heading = HEAD_W'($urandom());
      r.drain_first  = 1'b0;
      queued_requests.push_back(r);
   endtask

   // likewise the velocity fields of a pose load
   task automatic add_load(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                           input logic signed [HEAD_W-1:0] h);
      odo_request_type r;
      r.mode         = MODE_LOAD;
      r.vel_x        = VEL_W'($urandom());
      r.vel_y        = VEL_W'($urandom());
      r.turn_rate    = VEL_W'($urandom());
      r.step_time    = DT_W'($urandom());
      r.load_x       = x;
      r.load_y       = y;
      r.load_heading = h;
      r.drain_first  = 1'b0;
      queued_requests.push_back(r);
   endtask

   // ---------------------------------------------------------------
   // request driver, falling edge
   // ---------------------------------------------------------------
   odo_request_type cur_req;
   bit              offering;
   int              drv_wait;

   always @(negedge clock) begin
      if (!reset) begin
         // last offer taken at the rising edge just past
         if (offering && req_fire) begin
            offering = 1'b0;
         end
         if (!offering) begin
            if (drv_wait > 0) begin
               drv_wait--;
            end else if (queued_requests.size() != 0 &&
                         !(queued_requests[0].drain_first && pending_poses.size() != 0)) begin
               cur_req  = queued_requests.pop_front();
               offering = 1'b1;
               drv_wait = draw_wait(launched);
               launched++;
            end
         end
         req_bus.valid <= offering;
         if (offering) begin
            req_bus.mode         <= cur_req.mode;
            req_bus.vel_x        <= cur_req.vel_x;
            req_bus.vel_y        <= cur_req.vel_y;
            req_bus.turn_rate    <= cur_req.turn_rate;
            req_bus.step_time    <= cur_req.step_time;
            req_bus.load_x       <= cur_req.load_x;
            req_bus.load_y       <= cur_req.load_y;
            req_bus.load_heading <= cur_req.load_heading;
         end
      end
   end

   // ---------------------------------------------------------------
   // response backpressure, falling edge
   // ---------------------------------------------------------------
   int rsp_wait;
   int hold_left;

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) begin
            rsp_wait = draw_wait(results_seen);
            // two long stalls: the block fills up and must refuse requests
            if (results_seen == 150 || results_seen == 600) begin
               hold_left = LONG_HOLD;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor and scoreboard, rising edge
   // ---------------------------------------------------------------
   odo_request_type taken_req;
   pose_type        want_pose;

   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         rsp_fire <= rsp_bus.valid && rsp_bus.ready;

         // accepted request: predict the pose it returns
         if (req_bus.valid && req_bus.ready) begin
            taken_req.mode         = req_bus.mode;
            taken_req.vel_x        = req_bus.vel_x;
            taken_req.vel_y        = req_bus.vel_y;
            taken_req.turn_rate    = req_bus.turn_rate;
            taken_req.step_time    = req_bus.step_time;
            taken_req.load_x       = req_bus.load_x;
            taken_req.load_y       = req_bus.load_y;
            taken_req.load_heading = req_bus.load_heading;
            pending_poses.push_back(advance_pose(taken_req));
         end

         // accepted response: compare against the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (pending_poses.size() == 0) begin
               $error("unexpected response: pos_x %0d pos_y %0d heading %0d",
                      rsp_bus.pos_x, rsp_bus.pos_y, rsp_bus.heading);
               fail_count++;
            end else begin
               want_pose = pending_poses.pop_front();
               if (rsp_bus.pos_x !== want_pose.x) begin
                  $error("pos_x: expected %0d, got %0d", want_pose.x, rsp_bus.pos_x);
                  fail_count++;
               end
               if (rsp_bus.pos_y !== want_pose.y) begin
                  $error("pos_y: expected %0d, got %0d", want_pose.y, rsp_bus.pos_y);
                  fail_count++;
               end
               if (rsp_bus.heading !== want_pose.heading) begin
                  $error("heading: expected %0d, got %0d", want_pose.heading, rsp_bus.heading);
                  fail_count++;
               end
            end
         end

         // watchdog on handshake activity
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin
      logic        [DT_W-1:0]   dt;
      logic signed [HEAD_W-1:0] hd;

      // every input known from time zero
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.mode         = MODE_UPDATE;
      req_bus.vel_x        = '0;
      req_bus.vel_y        = '0;
      req_bus.turn_rate    = '0;
      req_bus.step_time    = '0;
      req_bus.load_x       = '0;
      req_bus.load_y       = '0;
      req_bus.load_heading = '0;
      rsp_bus.ready        = 1'b0;

      track_x       = HOME_POS;
      track_y       = HOME_POS;
      track_heading = HOME_HEADING;

      // directed part
      // zero elapsed time at the reset pose must hand back the reset pose
      add_update(pick_vel(), pick_vel(), pick_vel(), '0);
      // full-scale velocities over the longest step
      add_update(VEL_MAX, '0, '0, DT_MAX);
      add_update(VEL_MIN, VEL_MIN, VEL_MIN, DT_MAX);
      add_update(VEL_MAX, VEL_MAX, VEL_MAX, DT_MAX);
      // corner of the field, then push both axes past their limits
      add_load(X_MAX, X_MIN, '0);
      add_update(VEL_MAX, VEL_MIN, '0, DT_MAX);
      add_update(VEL_MAX, VEL_MIN, '0, DT_W'(1));
      // heading of exactly +pi wraps to -pi on load; turned by -pi the velocities move both axes in from their limits
      add_load(X_MIN, X_MAX, HEAD_W'(Q_PI));
      add_update(VEL_MIN, VEL_MAX, '0, DT_MAX);
      // loaded headings far outside [-pi, pi)
      add_load('0, '0, YAW_MIN);
      add_update(VEL_MAX, VEL_MAX, '0, DT_MAX);
      add_load('0, '0, YAW_MAX);
      add_update(VEL_MAX, VEL_MIN, '0, DT_MAX);
      // both sides of the quarter-turn pre-rotation threshold
      add_load('0, '0, HEAD_W'(Q_HALF_PI));
      add_update(VEL_MAX, VEL_MAX, '0, DT_MAX);
      add_load('0, '0, HEAD_W'(Q_HALF_PI + 1));
      add_update(VEL_MAX, VEL_MAX, '0, DT_MAX);
      add_load('0, '0, HEAD_W'(-Q_HALF_PI));
      add_update(VEL_MIN, VEL_MAX, '0, DT_MAX);
      add_load('0, '0, HEAD_W'(-Q_HALF_PI - 1));
      add_update(VEL_MIN, VEL_MAX, '0, DT_MAX);
      // heading wrap through -pi and through +pi
      add_load('0, '0, HEAD_W'(-Q_PI));
      add_update('0, '0, VEL_MIN, DT_MAX);
      add_update('0, '0, VEL_MAX, DT_MAX);
      add_update('0, '0, VEL_W'(1), DT_W'(1));

      // random part: mostly updates, some pose loads
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 99) < 15) begin
            if ($urandom_range(0, 4) == 0) begin
               hd = HEAD_W'($urandom());
            end else begin
               hd = HEAD_W'(longint'($urandom_range(0, Q_TWO_PI - 1)) - Q_PI);
            end
            add_load(pick_pos(), pick_pos(), hd);
         end else begin
            case ($urandom_range(0, 9))
               0:       dt = '0;
               1:       dt = DT_MAX;
               2, 3:    dt = DT_W'($urandom_range(1, 255));
               default: dt = DT_W'($urandom_range(0, DT_MAX));
            endcase
            add_update(pick_vel(), pick_vel(), pick_vel(), dt);
         end
         // sender goes quiet now and then until all responses are back
         if (n == 0 || n % 200 == 199) begin
            queued_requests[$].drain_first = 1'b1;
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // everything sent and everything answered
      while (queued_requests.size() != 0 || offering || pending_poses.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d updates and %0d pose loads, %0d responses checked",
               n_updates, n_loads, results_seen);
      $display("%0d position clamps and %0d quarter-turn pre-rotations predicted",
               n_clamps, n_quadrant);
      if (fail_count == 0 && pending_poses.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
